// File: rtl/pfpq_pkg.sv
// Package for the photo floor position qualifier.
// Holds the register indexes, reset values, position codes and the position decoder.
// No dependencies.
`default_nettype none

package pfpq_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_POLL       = 2'd1;
	localparam logic [1:0] REG_BOOT_GUARD = 2'd2;

	localparam int AGE_W  = 10;
	localparam int BOOT_W = 12;
	localparam int CFG_W  = 12;

	localparam logic [AGE_W-1:0]  DEBOUNCE_RST   = 10'd30;
	localparam logic [AGE_W-1:0]  POLL_RST       = 10'd50;
	localparam logic [BOOT_W-1:0] BOOT_GUARD_RST = 12'd200;

	typedef enum logic [2:0] {
		POS_MOVING     = 3'd0,
		POS_FLOOR1     = 3'd1,
		POS_FLOOR2     = 3'd2,
		POS_FLOOR3     = 3'd3,
		POS_BETWEEN_12 = 3'd4,
		POS_BETWEEN_23 = 3'd5,
		POS_ERROR      = 3'd6
	} position_t;

	function automatic position_t decode_position(input logic [2:0] bits);
		position_t pos;
		case (bits)
			3'b000: pos = POS_MOVING;
			3'b001: pos = POS_FLOOR1;
			3'b010: pos = POS_FLOOR2;
			3'b100: pos = POS_FLOOR3;
			3'b011: pos = POS_BETWEEN_12;
			3'b110: pos = POS_BETWEEN_23;
			default: pos = POS_ERROR;
		endcase
		return pos;
	endfunction

endpackage

`default_nettype wire

// File: rtl/photo_floor_position_qualifier_core.sv
// Photo floor position qualifier: debounce, backup poll and position decode.
// Depends on pfpq_pkg.
//
// Usage: every input transaction is one millisecond tick carrying edge_event and the
// three beam bits. Each tick produces exactly one output transaction with changed,
// position and latched_bits. The first tick after reset latches the beams silently;
// after that edges are ignored until boot_guard_ms ticks have passed, an accepted edge
// holds off resampling for debounce_ms ticks, and a backup poll resamples every
// poll_period_ms ticks.
// The result is presented in the output register in the cycle after the input
// transaction. Throughput: one tick per cycle; the only storage between the sides is
// the single output register, so in_stall rises only while that register is full and
// out_stall is high. A stalled result holds its value.
// Reset: clears all counters, the pending flag and the first-tick flag, loads the
// configuration defaults (30, 50, 200) and empties the output register.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the next edge; the
// user must make them while the block is idle, which the block itself leaves unenforced.
`default_nettype none

module photo_floor_position_qualifier_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config port
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        edge_event,
	input  wire logic        beam_one,
	input  wire logic        beam_two,
	input  wire logic        beam_three,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             changed,
	output logic [2:0]       position,
	output logic [2:0]       latched_bits
);

	localparam int AW = pfpq_pkg::AGE_W;
	localparam int BW = pfpq_pkg::BOOT_W;

	logic [AW-1:0] debounce_q, poll_period_q;
	logic [BW-1:0] boot_guard_q;

	logic [2:0]    latched_q;
	logic          first_done_q;
	logic          pending_q;
	logic [AW-1:0] edge_age_q, poll_age_q;
	logic [BW-1:0] boot_age_q;

	logic          in_acc;
	logic [2:0]    now_bits;
	logic [BW-1:0] boot_inc;
	logic [AW-1:0] edge_inc, poll_inc;
	logic          edge_ok, pend_any, hold, poll_hit, do_sample, chg;
	logic [AW-1:0] edge_age_d, poll_age_d;
	logic          pending_d;
	logic [2:0]    latched_d;

	assign in_stall = out_valid && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign now_bits = {beam_three, beam_two, beam_one};

	always_comb begin
		boot_inc = (boot_age_q == {BW{1'b1}}) ? boot_age_q : boot_age_q + 1'b1;
		edge_inc = (edge_age_q == {AW{1'b1}}) ? edge_age_q : edge_age_q + 1'b1;
		poll_inc = (poll_age_q == {AW{1'b1}}) ? poll_age_q : poll_age_q + 1'b1;

		edge_ok    = edge_event && (boot_inc >= boot_guard_q);
		pend_any   = pending_q || edge_ok;
		edge_age_d = edge_ok ? '0 : edge_inc;
		hold       = pend_any && (edge_age_d < debounce_q);
		poll_hit   = !hold && (poll_inc >= poll_period_q);
		poll_age_d = poll_hit ? '0 : poll_inc;
		pending_d  = hold;
		// pending resample and poll resample both reduce to one compare against now_bits
		do_sample  = !hold && (pend_any || poll_hit);
		chg        = do_sample && (now_bits != latched_q);
		latched_d  = do_sample ? now_bits : latched_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= pfpq_pkg::DEBOUNCE_RST;
			poll_period_q <= pfpq_pkg::POLL_RST;
			boot_guard_q  <= pfpq_pkg::BOOT_GUARD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pfpq_pkg::REG_DEBOUNCE:   debounce_q    <= cfg_data[AW-1:0];
				pfpq_pkg::REG_POLL:       poll_period_q <= cfg_data[AW-1:0];
				pfpq_pkg::REG_BOOT_GUARD: boot_guard_q  <= cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q    <= '0;
			first_done_q <= 1'b0;
			pending_q    <= 1'b0;
			edge_age_q   <= '0;
			poll_age_q   <= '0;
			boot_age_q   <= '0;
		end else if (in_acc) begin
			if (!first_done_q) begin
				latched_q    <= now_bits;
				first_done_q <= 1'b1;
			end else begin
				latched_q  <= latched_d;
				pending_q  <= pending_d;
				edge_age_q <= edge_age_d;
				poll_age_q <= poll_age_d;
				boot_age_q <= boot_inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_acc) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (!first_done_q) begin
				changed      <= 1'b0;
				latched_bits <= now_bits;
				position     <= pfpq_pkg::decode_position(now_bits);
			end else begin
				changed      <= chg;
				latched_bits <= latched_d;
				position     <= pfpq_pkg::decode_position(latched_d);
			end
		end
	end

`ifndef SYNTH
	a_pos_decode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position == pfpq_pkg::decode_position(latched_bits))
		else $error("position does not match latched_bits");

	a_bits_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_acc) |-> latched_bits == latched_q)
		else $error("output bits differ from latched state");

	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !first_done_q) |=> !changed)
		else $error("changed set on first tick");

	a_first_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(first_done_q))
		else $error("first-tick flag dropped");
`endif

endmodule

`default_nettype wire
